/* hw/rtl/owtp_pkg.sv */
// Shared types and constants for the single-wire temperature poller.
// Used by owtp_ctrl, owtp_digits and the top level onewire_temperature_poller.
package owtp_pkg;

    localparam int CNT_W = 18;
    localparam int TENTHS_W = 16;
    localparam int HUNDREDS_W = 9;
    localparam int DIGIT_W = 4;

    typedef struct packed {
        logic                bus_low;
        logic                reading_valid;
        logic [TENTHS_W-1:0] tenths;
    } owtp_tick_t;

endpackage

/* hw/rtl/owtp_ctrl.sv */
// Bus sequencer of the poller: timing registers, phase machine and reading capture.
// Depends on owtp_pkg for the counter width and the per-tick result word.
module owtp_ctrl
    import owtp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_index,
    input  logic [17:0]      cfg_data,
    input  logic             step,
    input  logic             line_high,
    output owtp_tick_t       tick
);

    localparam logic [3:0] PH_RST1_LOW  = 4'd0;
    localparam logic [3:0] PH_RST1_WAIT = 4'd1;
    localparam logic [3:0] PH_WR_CONV   = 4'd2;
    localparam logic [3:0] PH_CONV_WAIT = 4'd3;
    localparam logic [3:0] PH_RST2_LOW  = 4'd4;
    localparam logic [3:0] PH_RST2_WAIT = 4'd5;
    localparam logic [3:0] PH_WR_READ   = 4'd6;
    localparam logic [3:0] PH_READ      = 4'd7;

    localparam logic [1:0] REG_RESET_LOW     = 2'd0;
    localparam logic [1:0] REG_PRESENCE_WAIT = 2'd1;
    localparam logic [1:0] REG_SLOT          = 2'd2;
    localparam logic [1:0] REG_CONVERT_WAIT  = 2'd3;

    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    logic [9:0]          reset_low_reg;
    logic [9:0]          presence_wait_reg;
    logic [7:0]          slot_reg;
    logic [17:0]         convert_wait_reg;

    logic [3:0]          phase_reg, phase_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [2:0]          bit_reg, bit_next;
    logic                byte_reg, byte_next;
    logic [7:0]          shift_reg, shift_next;
    logic [15:0]         raw_reg, raw_next;
    logic [TENTHS_W-1:0] tenths_reg, tenths_next;

    logic                bus;
    logic                valid;
    logic [7:0]          slot_lim;
    logic [CNT_W-1:0]    slot_ext;
    logic [CNT_W-1:0]    count_inc;
    logic [2:0]          bit_inc;
    logic [7:0]          cmd;
    logic [18:0]         raw_times5;

    function automatic logic span_over(input logic [CNT_W-1:0] cnt,
                                       input logic [CNT_W-1:0] lim);
        logic [CNT_W-1:0] l;
        logic [CNT_W:0]   s;
        l = (lim == '0) ? CNT_W'(1) : lim;
        s = {1'b0, cnt} + (CNT_W+1)'(1);
        return s >= {1'b0, l};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_low_reg     <= 10'd130;
            presence_wait_reg <= 10'd140;
            slot_reg          <= 8'd30;
            convert_wait_reg  <= 18'd250000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RESET_LOW:     reset_low_reg     <= cfg_data[9:0];
                REG_PRESENCE_WAIT: presence_wait_reg <= cfg_data[9:0];
                REG_SLOT:          slot_reg          <= cfg_data[7:0];
                REG_CONVERT_WAIT:  convert_wait_reg  <= cfg_data;
                default:           reset_low_reg     <= reset_low_reg;
            endcase
        end
    end

    assign slot_lim  = (slot_reg == 8'd0) ? 8'd1 : slot_reg;
    assign slot_ext  = CNT_W'(slot_lim);
    assign count_inc = count_reg + CNT_W'(1);
    assign bit_inc   = bit_reg + 3'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        bit_next    = bit_reg;
        byte_next   = byte_reg;
        shift_next  = shift_reg;
        raw_next    = raw_reg;
        tenths_next = tenths_reg;
        bus         = 1'b0;
        valid       = 1'b0;
        cmd         = CMD_SKIP_ROM;
        raw_times5  = '0;

        unique case (phase_reg) inside
            PH_RST1_LOW, PH_RST2_LOW:
            begin
                bus = 1'b1;
                if (span_over(count_reg, CNT_W'(reset_low_reg)))
                begin
                    phase_next = phase_reg + 4'd1;
                    count_next = '0;
                    bit_next   = '0;
                    byte_next  = 1'b0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_RST1_WAIT, PH_RST2_WAIT, PH_CONV_WAIT:
            begin
                if (span_over(count_reg, (phase_reg == PH_CONV_WAIT) ?
                              CNT_W'(convert_wait_reg) : CNT_W'(presence_wait_reg)))
                begin
                    phase_next = phase_reg + 4'd1;
                    count_next = '0;
                    bit_next   = '0;
                    byte_next  = 1'b0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_WR_CONV, PH_WR_READ:
            begin
                if (byte_reg)
                begin
                    cmd = (phase_reg == PH_WR_CONV) ? CMD_CONVERT : CMD_READ_PAD;
                end
                bus = (count_reg == '0) || (!cmd[bit_reg] && (count_reg < slot_ext));
                if (count_reg >= slot_ext)
                begin
                    count_next = '0;
                    bit_next   = bit_inc;
                    if (bit_inc == 3'd0)
                    begin
                        if (byte_reg)
                        begin
                            phase_next = phase_reg + 4'd1;
                            byte_next  = 1'b0;
                        end
                        else
                        begin
                            byte_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_READ:
            begin
                bus = (count_reg == '0);
                if (count_reg == CNT_W'(1))
                begin
                    shift_next = {line_high, shift_reg[7:1]};
                end
                if (count_reg >= slot_ext)
                begin
                    count_next = '0;
                    bit_next   = bit_inc;
                    if (bit_inc == 3'd0)
                    begin
                        if (!byte_reg)
                        begin
                            raw_next  = {raw_reg[15:8], shift_next};
                            byte_next = 1'b1;
                        end
                        else
                        begin
                            raw_next    = {shift_next, raw_reg[7:0]};
                            raw_times5  = {3'b000, raw_next} + {1'b0, raw_next, 2'b00};
                            tenths_next = raw_times5[18:3];
                            valid       = 1'b1;
                            phase_next  = PH_RST1_LOW;
                            byte_next   = 1'b0;
                        end
                    end
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            default:
            begin
                phase_next = PH_RST1_LOW;
                count_next = '0;
                bit_next   = '0;
                byte_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RST1_LOW;
            count_reg  <= '0;
            bit_reg    <= '0;
            byte_reg   <= 1'b0;
            shift_reg  <= '0;
            raw_reg    <= '0;
            tenths_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            bit_reg    <= bit_next;
            byte_reg   <= byte_next;
            shift_reg  <= shift_next;
            raw_reg    <= raw_next;
            tenths_reg <= tenths_next;
        end
    end

    assign tick.bus_low       = bus;
    assign tick.reading_valid = valid;
    assign tick.tenths        = tenths_next;

endmodule

/* hw/rtl/owtp_digits.sv */
// Three-stage result pipeline: tick word register, hundreds by reciprocal, tens and ones.
// Depends on owtp_pkg for the tick word type and the field widths.
module owtp_digits
    import owtp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  owtp_tick_t            s_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  bus_low,
    output logic                  reading_valid,
    output logic [TENTHS_W-1:0]   tenths_value,
    output logic [HUNDREDS_W-1:0] digit_hundreds,
    output logic [DIGIT_W-1:0]    digit_tens,
    output logic [DIGIT_W-1:0]    digit_ones
);

    localparam int PROD_W = TENTHS_W + 13;
    localparam logic [PROD_W-1:0] RECIP_100 = PROD_W'(5243);
    localparam int RECIP_SHIFT = 19;

    logic                  v1_reg, v2_reg, v3_reg;
    owtp_tick_t            w1_reg, w2_reg;
    logic [HUNDREDS_W-1:0] q2_reg;
    logic                  adv1, adv2, adv3;
    logic [PROD_W-1:0]     prod;
    logic [TENTHS_W-1:0]   hundreds_x100;
    logic [TENTHS_W-1:0]   rem_full;
    logic [6:0]            rem;
    logic [DIGIT_W-1:0]    tens;
    logic [6:0]            tens_x10;

    // The quotient estimate is exact for every tenths value the sequencer can produce.
    function automatic logic [DIGIT_W-1:0] tens_of(input logic [6:0] r);
        logic [DIGIT_W-1:0] t;
        t = '0;
        for (int k = 1; k < 10; k++)
        begin
            if (r >= 7'(10 * k))
            begin
                t = DIGIT_W'(k);
            end
        end
        return t;
    endfunction

    assign adv3    = !v3_reg || !out_stall;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    assign prod          = PROD_W'(w1_reg.tenths) * RECIP_100;
    assign hundreds_x100 = TENTHS_W'(q2_reg) * TENTHS_W'(100);
    assign rem_full      = w2_reg.tenths - hundreds_x100;
    assign rem           = rem_full[6:0];
    assign tens          = tens_of(rem);
    assign tens_x10      = 7'(tens) * 7'd10;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= s_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && s_valid)
        begin
            w1_reg <= s_word;
        end
        if (adv2 && v1_reg)
        begin
            w2_reg <= w1_reg;
            q2_reg <= prod[RECIP_SHIFT+HUNDREDS_W-1:RECIP_SHIFT];
        end
        if (adv3 && v2_reg)
        begin
            bus_low        <= w2_reg.bus_low;
            reading_valid  <= w2_reg.reading_valid;
            tenths_value   <= w2_reg.tenths;
            digit_hundreds <= q2_reg;
            digit_tens     <= tens;
            digit_ones     <= DIGIT_W'(rem - tens_x10);
        end
    end

    assign out_valid = v3_reg;

endmodule

/* hw/rtl/onewire_temperature_poller.sv */
// Top level of the single-wire temperature poller: configuration port, sequencer, digits.
// Depends on owtp_pkg, owtp_ctrl and owtp_digits.
//
// Each input word is one time-unit tick carrying the sampled bus level (line_high).
// The block answers every tick with one output word: the bus drive for that tick
// (bus_low), a one-tick reading_valid strobe, the latest reading in tenths and its
// hundreds, tens and ones digits. Out of reset the sequencer starts a reset pulse,
// the timing registers hold their default values and the shown reading is zero.
// An input word is accepted when in_valid is high and in_stall is low; the result
// word then passes through the sequencer step, then the hundreds multiply by
// reciprocal, then the tens/ones split, each ending in a register.
// Throughput is one tick per clock cycle while out_stall is low. When the
// receiver holds out_stall, the pipeline fills and in_stall rises once all three
// stages are occupied; no word is dropped and the stalled output word holds steady.
// Timing registers are written through cfg_valid/cfg_ready with cfg_index 0 to 3
// (reset low, presence wait, slot, conversion wait); cfg_ready is always high and
// writes are meant for idle periods.
module onewire_temperature_poller
    import owtp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [17:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  line_high,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  bus_low,
    output logic                  reading_valid,
    output logic [TENTHS_W-1:0]   tenths_value,
    output logic [HUNDREDS_W-1:0] digit_hundreds,
    output logic [DIGIT_W-1:0]    digit_tens,
    output logic [DIGIT_W-1:0]    digit_ones
);

    owtp_tick_t tick;
    logic       pipe_ready;
    logic       step;

    assign cfg_ready = 1'b1;
    assign in_stall  = !pipe_ready;
    assign step      = in_valid && pipe_ready;

    owtp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .line_high (line_high),
        .tick      (tick)
    );

    owtp_digits u_digits (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_valid        (in_valid),
        .s_ready        (pipe_ready),
        .s_word         (tick),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .bus_low        (bus_low),
        .reading_valid  (reading_valid),
        .tenths_value   (tenths_value),
        .digit_hundreds (digit_hundreds),
        .digit_tens     (digit_tens),
        .digit_ones     (digit_ones)
    );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for onewire_temperature_poller: a directed table, then random ticks
// over many timing settings, each output word checked against a behavioral model of the poller.
// Depends on owtp_pkg and the poller RTL; needs no files or arguments.
module tb_top;
    import owtp_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0]
    {
        REG_RESET_LOW,
        REG_PRESENCE_WAIT,
        REG_SLOT,
        REG_CONVERT_WAIT
    } reg_index_e;

    typedef enum logic [3:0]
    {
        SEQ_RST1_LOW,
        SEQ_RST1_WAIT,
        SEQ_WR_CONV,
        SEQ_CONV_WAIT,
        SEQ_RST2_LOW,
        SEQ_RST2_WAIT,
        SEQ_WR_READ,
        SEQ_READ
    } seq_phase_e;

    typedef enum logic [1:0]
    {
        LINE_NOISE,
        LINE_ALL_HIGH,
        LINE_ALL_LOW,
        LINE_TOGGLE
    } line_mode_e;

    typedef enum logic
    {
        ROW_TICK,
        ROW_WRITE
    } row_kind_e;

    typedef struct packed
    {
        logic                  bus_low;
        logic                  reading_valid;
        logic [TENTHS_W-1:0]   tenths;
        logic [HUNDREDS_W-1:0] hundreds;
        logic [DIGIT_W-1:0]    tens;
        logic [DIGIT_W-1:0]    ones;
    } tick_word_t;

    typedef struct packed
    {
        row_kind_e   kind;
        logic        line;
        reg_index_e  index;
        logic [17:0] data;
        logic        typed;
    } plan_row_t;

    localparam tick_word_t RESET_PULSE_WORD = '{1'b1, 1'b0, 16'd0, 9'd0, 4'd0, 4'd0};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [17:0]           cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  line_high;
    logic                  out_valid;
    logic                  out_stall;
    logic                  bus_low;
    logic                  reading_valid;
    logic [TENTHS_W-1:0]   tenths_value;
    logic [HUNDREDS_W-1:0] digit_hundreds;
    logic [DIGIT_W-1:0]    digit_tens;
    logic [DIGIT_W-1:0]    digit_ones;

    logic [9:0]       reset_low_setting = 10'd130;
    logic [9:0]       presence_setting = 10'd140;
    logic [7:0]       slot_setting = 8'd30;
    logic [17:0]      convert_setting = 18'd250000;
    seq_phase_e       seq_phase = SEQ_RST1_LOW;
    logic [CNT_W-1:0] unit_count = '0;
    logic [2:0]       bit_pos = '0;
    logic             byte_pos = 1'b0;
    logic [7:0]       shift_in = '0;
    logic [15:0]      raw_value = '0;
    logic [15:0]      shown_tenths = '0;

    tick_word_t pending_words[$];
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int failures = 0;
    int ticks_sent = 0;
    int writes_done = 0;
    int readings_done = 0;
    int words_taken = 0;

    onewire_temperature_poller DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void advance_phase();
        seq_phase = seq_phase_e'(seq_phase + 4'd1);
        unit_count = '0;
        bit_pos = '0;
        byte_pos = 1'b0;
    endfunction

    function automatic void timed_phase(input logic [17:0] limit);
        longint unsigned span;
        span = (limit == 0) ? 64'd1 : 64'(limit);
        if (span > COUNT_MAX)
            span = COUNT_MAX;
        if (64'(unit_count) + 64'd1 >= span)
            advance_phase();
        else
            unit_count = unit_count + 1'b1;
    endfunction

    function automatic tick_word_t advance_poller(input logic lh);
        tick_word_t word;
        logic [7:0] command;
        logic [7:0] slot;
        logic bus;
        int unsigned scaled;
        bus = 1'b0;
        word.reading_valid = 1'b0;
        slot = (slot_setting == 0) ? 8'd1 : slot_setting;
        case (seq_phase)
            SEQ_RST1_LOW, SEQ_RST2_LOW:
            begin
                bus = 1'b1;
                timed_phase(reset_low_setting);
            end
            SEQ_RST1_WAIT, SEQ_RST2_WAIT:
                timed_phase(presence_setting);
            SEQ_CONV_WAIT:
                timed_phase(convert_setting);
            SEQ_WR_CONV, SEQ_WR_READ:
            begin
                if (!byte_pos)
                    command = CMD_SKIP_ROM;
                else
                    command = (seq_phase == SEQ_WR_CONV) ? CMD_CONVERT : CMD_READ_PAD;
                bus = (unit_count == 0) || (!command[bit_pos] && unit_count < slot);
                if (unit_count >= slot)
                begin
                    unit_count = '0;
                    bit_pos = bit_pos + 1'b1;
                    if (bit_pos == 0)
                    begin
                        if (byte_pos)
                            advance_phase();
                        else
                            byte_pos = 1'b1;
                    end
                end
                else
                    unit_count = unit_count + 1'b1;
            end
            SEQ_READ:
            begin
                bus = (unit_count == 0);
                if (unit_count == 1)
                    shift_in = {lh, shift_in[7:1]};
                if (unit_count >= slot)
                begin
                    unit_count = '0;
                    bit_pos = bit_pos + 1'b1;
                    if (bit_pos == 0)
                    begin
                        if (!byte_pos)
                        begin
                            raw_value[7:0] = shift_in;
                            byte_pos = 1'b1;
                        end
                        else
                        begin
                            raw_value[15:8] = shift_in;
                            scaled = (32'(raw_value) * 32'd5) >> 3;
                            shown_tenths = scaled[15:0];
                            word.reading_valid = 1'b1;
                            readings_done++;
                            seq_phase = SEQ_RST1_LOW;
                            byte_pos = 1'b0;
                        end
                    end
                end
                else
                    unit_count = unit_count + 1'b1;
            end
            default:
            begin
                seq_phase = SEQ_RST1_LOW;
                unit_count = '0;
                bit_pos = '0;
                byte_pos = 1'b0;
            end
        endcase
        word.bus_low = bus;
        word.tenths = shown_tenths;
        word.hundreds = HUNDREDS_W'(shown_tenths / 16'd100);
        word.tens = DIGIT_W'((shown_tenths % 16'd100) / 16'd10);
        word.ones = DIGIT_W'(shown_tenths % 16'd10);
        return word;
    endfunction

    function automatic logic [17:0] pick_setting(input int width);
        logic [17:0] value;
        case ($urandom_range(0, 11))
            0: value = 18'd0;
            1: value = 18'($urandom_range(0, (1 << width) - 1));
            default: value = 18'($urandom_range(1, 4));
        endcase
        if ($urandom_range(0, 5) == 0)
            value = value | (18'($urandom) << width);
        return value;
    endfunction

    function automatic logic drive_level(input line_mode_e mode, input logic prev);
        case (mode)
            LINE_ALL_HIGH: return 1'b1;
            LINE_ALL_LOW: return 1'b0;
            LINE_TOGGLE: return !prev;
            default: return logic'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    task automatic send_tick(input logic lh, input logic typed);
        int gap;
        tick_word_t word;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        @(negedge clk);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        line_high <= lh;
        do @(posedge clk); while (in_stall !== 1'b0);
        word = advance_poller(lh);
        pending_words.push_back(typed ? RESET_PULSE_WORD : word);
        ticks_sent++;
    endtask

    task automatic write_reg(input reg_index_e idx, input logic [17:0] data);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            REG_RESET_LOW: reset_low_setting = data[9:0];
            REG_PRESENCE_WAIT: presence_setting = data[9:0];
            REG_SLOT: slot_setting = data[7:0];
            default: convert_setting = data;
        endcase
        writes_done++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : receive_words
        int stall_cycles;
        tick_word_t want;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall_cycles = rx_idle ? $urandom_range(0, 9) : 0;
            if (words_taken == 50 || words_taken % 700 == 350)
                stall_cycles = $urandom_range(150, 300);
            @(negedge clk);
            repeat (stall_cycles)
            begin
                out_stall <= 1'b1;
                @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            words_taken++;
            if (pending_words.size() == 0)
            begin
                $error("output word arrived with nothing expected");
                failures++;
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("bus_low", want.bus_low, bus_low);
                check_field("reading_valid", want.reading_valid, reading_valid);
                check_field("tenths_value", want.tenths, tenths_value);
                check_field("digit_hundreds", want.hundreds, digit_hundreds);
                check_field("digit_tens", want.tens, digit_tens);
                check_field("digit_ones", want.ones, digit_ones);
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        plan_row_t plan[$];
        line_mode_e mode;
        logic level;
        int phase_ticks;
        int random_ticks;
        int mark;
        rst_n = 1'b0;
        in_valid = 1'b0;
        line_high = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Out of reset the poller drives its first reset pulse and shows zero.
        for (int i = 0; i < 6; i++)
            plan.push_back('{ROW_TICK, logic'(i % 2), REG_RESET_LOW, 18'd0, 1'b1});
        // A zero pulse length acts as one, so the running pulse ends on the next tick.
        plan.push_back('{ROW_WRITE, 1'b0, REG_RESET_LOW, 18'd0, 1'b0});
        plan.push_back('{ROW_WRITE, 1'b0, REG_PRESENCE_WAIT, 18'h3FC02, 1'b0});
        plan.push_back('{ROW_WRITE, 1'b0, REG_SLOT, 18'h3FF00, 1'b0});
        plan.push_back('{ROW_WRITE, 1'b0, REG_CONVERT_WAIT, 18'd1, 1'b0});
        plan.push_back('{ROW_TICK, 1'b1, REG_RESET_LOW, 18'd0, 1'b1});
        for (int i = 0; i < 12; i++)
            plan.push_back('{ROW_TICK, logic'($urandom_range(0, 1)), REG_RESET_LOW, 18'd0, 1'b0});
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_TICK)
                send_tick(plan[i].line, plan[i].typed);
            else
                write_reg(plan[i].index, plan[i].data);
        end

        mode = LINE_NOISE;
        level = 1'b0;
        random_ticks = 0;
        while (random_ticks < 500)
        begin
            if ($urandom_range(0, 1))
                write_reg(REG_RESET_LOW, pick_setting(10));
            if ($urandom_range(0, 1))
                write_reg(REG_PRESENCE_WAIT, pick_setting(10));
            if ($urandom_range(0, 1))
                write_reg(REG_SLOT, pick_setting(8));
            if ($urandom_range(0, 1))
            begin
                if ($urandom_range(0, 9) == 0)
                    write_reg(REG_CONVERT_WAIT, 18'($urandom_range(0, 300)));
                else
                    write_reg(REG_CONVERT_WAIT, 18'($urandom_range(1, 8)));
            end
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            phase_ticks = $urandom_range(50, 200);
            repeat (phase_ticks)
            begin
                mark = readings_done;
                level = drive_level(mode, level);
                send_tick(level, 1'b0);
                if (readings_done != mark)
                    mode = line_mode_e'($urandom_range(0, 3));
            end
            random_ticks += phase_ticks;
        end

        // Finish the current reading so the longest settings start from a fresh poll.
        write_reg(REG_RESET_LOW, 18'd1);
        write_reg(REG_PRESENCE_WAIT, 18'd1);
        write_reg(REG_SLOT, 18'd1);
        write_reg(REG_CONVERT_WAIT, 18'd1);
        mark = readings_done;
        while (readings_done == mark)
        begin
            level = drive_level(mode, level);
            send_tick(level, 1'b0);
        end
        // Short pulses let back-to-back ticks reach a full-length write slot.
        write_reg(REG_RESET_LOW, 18'd2);
        write_reg(REG_PRESENCE_WAIT, 18'd3);
        write_reg(REG_SLOT, 18'd255);
        write_reg(REG_CONVERT_WAIT, 18'd262143);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (300)
            send_tick(1'b1, 1'b0);
        write_reg(REG_RESET_LOW, 18'd1023);
        write_reg(REG_PRESENCE_WAIT, 18'd1023);

        write_reg(REG_RESET_LOW, 18'd1);
        write_reg(REG_PRESENCE_WAIT, 18'd1);
        write_reg(REG_SLOT, 18'd1);
        write_reg(REG_CONVERT_WAIT, 18'd1);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (200)
        begin
            level = drive_level(LINE_TOGGLE, level);
            send_tick(level, 1'b0);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d ticks with %0d register writes, from minimum to maximum timings.",
                 ticks_sent, writes_done);
        $display("Completed %0d readings; the last showed %0d tenths.",
                 readings_done, shown_tenths);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
